FILE: design/rbfe_pkg.sv
// ----------------------------------------------------------------------------
// rbfe_pkg
// shared types, codes and constants of the rgb bulb fade engine
// ----------------------------------------------------------------------------
package rbfe_pkg;

  localparam int unsigned COLOR_W     = 8;
  localparam int unsigned STEP_W      = 16;
  localparam int unsigned BULB_W      = 4;
  localparam int unsigned ACTION_W    = 3;
  localparam int unsigned FACTOR_W    = 6;   // 2*idx+4 for idx up to 15
  localparam int unsigned PROD_W      = 22;  // step times factor
  localparam int unsigned FRAC_W      = 8;   // q8.8 fraction bits of the step
  localparam int unsigned DIVIDEND_W  = PROD_W - FRAC_W;
  localparam int unsigned DIVISOR_W   = 5;   // 3*num_bulbs, at most 18
  localparam int unsigned QUOT_W      = DIVIDEND_W;
  localparam int unsigned DIV_CNT_W   = 4;
  localparam int unsigned NB_W        = 3;
  localparam int unsigned CFG_DATA_W  = 8;
  localparam int unsigned CFG_IDX_W   = 1;

  localparam logic [NB_W-1:0]    NUM_BULBS_MIN   = 3'd1;
  localparam logic [NB_W-1:0]    NUM_BULBS_MAX   = 3'd6;
  localparam logic [NB_W-1:0]    NUM_BULBS_RESET = 3'd1;
  localparam logic [COLOR_W-1:0] SNAP_THR_RESET  = 8'd12;

  typedef enum logic [ACTION_W-1:0] {
    ACT_TICK    = 3'd0,
    ACT_SET_TGT = 3'd1,
    ACT_SET_CUR = 3'd2,
    ACT_ALL_TGT = 3'd3,
    ACT_ALL_CUR = 3'd4,
    ACT_READ    = 3'd5
  } action_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NUM_BULBS = 1'b0,
    CFG_SNAP_THR  = 1'b1
  } cfg_reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_WRITE,
    ST_SWEEP,
    ST_MUL,
    ST_DIV_GO,
    ST_DIV,
    ST_APPLY,
    ST_FINISH
  } ctrl_state_e;

  typedef struct packed {
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
  } rgb_t;

  localparam rgb_t CUR_RESET = '{red: 8'd0,   green: 8'd0, blue: 8'd0};
  localparam rgb_t TGT_RESET = '{red: 8'd128, green: 8'd0, blue: 8'd77};

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [BULB_W-1:0]   bulb;
    logic [COLOR_W-1:0]  red;
    logic [COLOR_W-1:0]  green;
    logic [COLOR_W-1:0]  blue;
    logic [STEP_W-1:0]   step_size;
  } in_item_t;

  typedef struct packed {
    logic [BULB_W-1:0]  bulb_index;
    logic [COLOR_W-1:0] cur_red;
    logic [COLOR_W-1:0] cur_green;
    logic [COLOR_W-1:0] cur_blue;
    logic [COLOR_W-1:0] tgt_red;
    logic [COLOR_W-1:0] tgt_green;
    logic [COLOR_W-1:0] tgt_blue;
    logic               still_fading;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic load_in;
    logic clr_idx;
    logic inc_idx;
    logic use_bulb;
    logic wr_tgt;
    logic wr_cur;
    logic wr_fade;
    logic mul_en;
    logic div_start;
    logic out_load;
  } ctl_cmd_t;

  // datapath to controller
  typedef struct packed {
    action_e action;
    logic    last_idx;
    logic    div_busy;
    logic    out_free;
  } dp_status_t;

endpackage

FILE: design/rbfe_div.sv
// ----------------------------------------------------------------------------
// rbfe_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module rbfe_div (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [rbfe_pkg::DIVIDEND_W-1:0]  dividend_i,
  input  logic [rbfe_pkg::DIVISOR_W-1:0]   divisor_i,
  output logic                             busy_o,
  output logic [rbfe_pkg::QUOT_W-1:0]      quot_o,
  output logic [rbfe_pkg::DIVISOR_W-1:0]   rem_o
);

  localparam logic [rbfe_pkg::DIV_CNT_W-1:0] DIV_STEPS =
    rbfe_pkg::DIV_CNT_W'(rbfe_pkg::DIVIDEND_W);

  logic                               busy_q, busy_d;
  logic [rbfe_pkg::DIV_CNT_W-1:0]     cnt_q, cnt_d;
  logic [rbfe_pkg::QUOT_W-1:0]        quot_q, quot_d;
  logic [rbfe_pkg::DIVISOR_W-1:0]     rem_q, rem_d;
  logic [rbfe_pkg::DIVISOR_W-1:0]     dvsr_q, dvsr_d;
  logic [rbfe_pkg::DIVISOR_W:0]       shifted;
  logic [rbfe_pkg::DIVISOR_W:0]       trial;
  logic                               fits;

  always_comb begin
    shifted = {rem_q, quot_q[rbfe_pkg::QUOT_W-1]};
    trial   = shifted - {1'b0, dvsr_q};
    fits    = shifted >= {1'b0, dvsr_q};
    busy_d  = busy_q;
    cnt_d   = cnt_q;
    quot_d  = quot_q;
    rem_d   = rem_q;
    dvsr_d  = dvsr_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = DIV_STEPS;
      quot_d = dividend_i;
      rem_d  = '0;
      dvsr_d = divisor_i;
    end else if (busy_q) begin
      rem_d  = fits ? trial[rbfe_pkg::DIVISOR_W-1:0] : shifted[rbfe_pkg::DIVISOR_W-1:0];
      quot_d = {quot_q[rbfe_pkg::QUOT_W-2:0], fits};
      cnt_d  = cnt_q - 1'b1;
      if (cnt_q == rbfe_pkg::DIV_CNT_W'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    dvsr_q <= dvsr_d;
  end

  assign busy_o = busy_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q;

endmodule

FILE: design/rbfe_dp.sv
// ----------------------------------------------------------------------------
// rbfe_dp
// colour stores, config registers, step multiply, channel update, result reg
// ----------------------------------------------------------------------------
module rbfe_dp #(
  parameter int unsigned BULB_SLOTS = 10
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  rbfe_pkg::in_item_t                in_data_i,
  input  logic                              cfg_we_i,
  input  logic [rbfe_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [rbfe_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  rbfe_pkg::ctl_cmd_t                cmd_i,
  output rbfe_pkg::dp_status_t              status_o,
  input  logic                              out_stall_i,
  output logic                              out_valid_o,
  output rbfe_pkg::out_item_t               out_data_o
);

  localparam int unsigned AW = (BULB_SLOTS > 1) ? $clog2(BULB_SLOTS) : 1;
  localparam logic [rbfe_pkg::BULB_W:0] SLOTS_EXT = (rbfe_pkg::BULB_W+1)'(BULB_SLOTS);
  localparam logic [AW-1:0]             LAST_IDX  = AW'(BULB_SLOTS - 1);

  rbfe_pkg::rgb_t                    cur_q [BULB_SLOTS];
  rbfe_pkg::rgb_t                    tgt_q [BULB_SLOTS];
  logic [BULB_SLOTS-1:0]             diff_q;

  rbfe_pkg::in_item_t                in_q;
  logic [rbfe_pkg::NB_W-1:0]         nb_q;
  logic [rbfe_pkg::COLOR_W-1:0]      thr_q;
  logic [AW-1:0]                     idx_q, idx_d;
  logic [rbfe_pkg::PROD_W-1:0]       prod_q;
  logic                              out_valid_q, out_valid_d;
  rbfe_pkg::out_item_t               out_q;

  logic                              bulb_ok;
  logic [AW-1:0]                     addr;
  logic                              addr_ok;
  rbfe_pkg::rgb_t                    rd_cur, rd_tgt;
  rbfe_pkg::rgb_t                    new_cur, new_tgt;
  rbfe_pkg::rgb_t                    in_rgb;
  rbfe_pkg::rgb_t                    fade_rgb;
  logic                              wr_en;
  logic [rbfe_pkg::FACTOR_W-1:0]     factor;
  logic [rbfe_pkg::PROD_W-1:0]       prod_d;
  logic [rbfe_pkg::DIVISOR_W-1:0]    divisor;
  logic [rbfe_pkg::QUOT_W-1:0]       quot;
  logic [rbfe_pkg::DIVISOR_W-1:0]    rem;
  logic                              div_busy;
  logic                              rem_nz;
  logic [rbfe_pkg::NB_W-1:0]         nb_sat;
  rbfe_pkg::out_item_t               out_d;

  // move one channel toward its target by the divided step
  function automatic logic [rbfe_pkg::COLOR_W-1:0] fade_ch(
    input logic [rbfe_pkg::COLOR_W-1:0] cur,
    input logic [rbfe_pkg::COLOR_W-1:0] tgt,
    input logic [rbfe_pkg::COLOR_W-1:0] thr,
    input logic [rbfe_pkg::QUOT_W-1:0]  q,
    input logic                         rnz
  );
    logic [rbfe_pkg::COLOR_W-1:0] gap;
    logic [rbfe_pkg::QUOT_W:0]    up_sum;
    logic [rbfe_pkg::QUOT_W:0]    down_amt;
    logic [rbfe_pkg::COLOR_W-1:0] res;
    gap      = (cur > tgt) ? (cur - tgt) : (tgt - cur);
    up_sum   = (rbfe_pkg::QUOT_W+1)'(cur) + (rbfe_pkg::QUOT_W+1)'(q);
    down_amt = (rbfe_pkg::QUOT_W+1)'(q) + (rbfe_pkg::QUOT_W+1)'(rnz);
    if (gap <= thr) begin
      res = tgt;
    end else if (tgt > cur) begin
      res = (up_sum > (rbfe_pkg::QUOT_W+1)'(255)) ? 8'hFF : up_sum[rbfe_pkg::COLOR_W-1:0];
    end else if (down_amt >= (rbfe_pkg::QUOT_W+1)'(cur)) begin
      res = '0;
    end else begin
      res = cur - down_amt[rbfe_pkg::COLOR_W-1:0];
    end
    return res;
  endfunction

  rbfe_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (prod_q[rbfe_pkg::PROD_W-1:rbfe_pkg::FRAC_W]),
    .divisor_i  (divisor),
    .busy_o     (div_busy),
    .quot_o     (quot),
    .rem_o      (rem)
  );

  always_comb begin
    bulb_ok = {1'b0, in_q.bulb} < SLOTS_EXT;
    addr    = cmd_i.use_bulb ? in_q.bulb[AW-1:0] : idx_q;
    addr_ok = cmd_i.use_bulb ? bulb_ok : 1'b1;
    rd_cur  = addr_ok ? cur_q[addr] : rbfe_pkg::CUR_RESET;
    rd_tgt  = addr_ok ? tgt_q[addr] : rbfe_pkg::CUR_RESET;
    in_rgb  = '{red: in_q.red, green: in_q.green, blue: in_q.blue};

    // step times 2*idx+4, divided by 3*num_bulbs after dropping the q8.8 fraction
    rem_nz  = (prod_q[rbfe_pkg::FRAC_W-1:0] != '0) || (rem != '0);
    fade_rgb.red   = fade_ch(rd_cur.red,   rd_tgt.red,   thr_q, quot, rem_nz);
    fade_rgb.green = fade_ch(rd_cur.green, rd_tgt.green, thr_q, quot, rem_nz);
    fade_rgb.blue  = fade_ch(rd_cur.blue,  rd_tgt.blue,  thr_q, quot, rem_nz);

    new_cur = rd_cur;
    new_tgt = rd_tgt;
    if (cmd_i.wr_tgt) begin
      new_tgt = in_rgb;
    end
    if (cmd_i.wr_cur) begin
      new_cur = in_rgb;
    end
    if (cmd_i.wr_fade) begin
      new_cur = fade_rgb;
    end
    wr_en = (cmd_i.wr_tgt || cmd_i.wr_cur || cmd_i.wr_fade) && addr_ok;

    factor  = rbfe_pkg::FACTOR_W'({idx_q, 1'b0}) + rbfe_pkg::FACTOR_W'(4);
    prod_d  = rbfe_pkg::PROD_W'(in_q.step_size) * rbfe_pkg::PROD_W'(factor);
    divisor = rbfe_pkg::DIVISOR_W'(nb_q) + rbfe_pkg::DIVISOR_W'({nb_q, 1'b0});

    idx_d = idx_q;
    if (cmd_i.clr_idx) begin
      idx_d = '0;
    end else if (cmd_i.inc_idx) begin
      idx_d = idx_q + 1'b1;
    end

    if (cfg_data_i < rbfe_pkg::CFG_DATA_W'(rbfe_pkg::NUM_BULBS_MIN)) begin
      nb_sat = rbfe_pkg::NUM_BULBS_MIN;
    end else if (cfg_data_i > rbfe_pkg::CFG_DATA_W'(rbfe_pkg::NUM_BULBS_MAX)) begin
      nb_sat = rbfe_pkg::NUM_BULBS_MAX;
    end else begin
      nb_sat = cfg_data_i[rbfe_pkg::NB_W-1:0];
    end

    out_d.bulb_index   = in_q.bulb;
    out_d.cur_red      = rd_cur.red;
    out_d.cur_green    = rd_cur.green;
    out_d.cur_blue     = rd_cur.blue;
    out_d.tgt_red      = rd_tgt.red;
    out_d.tgt_green    = rd_tgt.green;
    out_d.tgt_blue     = rd_tgt.blue;
    out_d.still_fading = |diff_q;

    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_i.out_load) begin
      out_valid_d = 1'b1;
    end
  end

  // colour stores with their reset colours and per-bulb mismatch flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < BULB_SLOTS; i++) begin
        cur_q[i] <= rbfe_pkg::CUR_RESET;
        tgt_q[i] <= rbfe_pkg::TGT_RESET;
      end
      diff_q <= (rbfe_pkg::CUR_RESET != rbfe_pkg::TGT_RESET) ? '1 : '0;
    end else if (wr_en) begin
      cur_q[addr]  <= new_cur;
      tgt_q[addr]  <= new_tgt;
      diff_q[addr] <= new_cur != new_tgt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nb_q        <= rbfe_pkg::NUM_BULBS_RESET;
      thr_q       <= rbfe_pkg::SNAP_THR_RESET;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (rbfe_pkg::cfg_reg_e'(cfg_index_i))
          rbfe_pkg::CFG_NUM_BULBS: nb_q  <= nb_sat;
          rbfe_pkg::CFG_SNAP_THR:  thr_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      in_q <= in_data_i;
    end
    if (cmd_i.mul_en) begin
      prod_q <= prod_d;
    end
    if (cmd_i.out_load) begin
      out_q <= out_d;
    end
  end

  assign status_o.action   = rbfe_pkg::action_e'(in_q.action);
  assign status_o.last_idx = idx_q == LAST_IDX;
  assign status_o.div_busy = div_busy;
  assign status_o.out_free = !out_valid_q || !out_stall_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

FILE: design/rbfe_ctrl.sv
// ----------------------------------------------------------------------------
// rbfe_ctrl
// sequencer for writes, sweeps over all bulbs and the tick loop
// ----------------------------------------------------------------------------
module rbfe_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  rbfe_pkg::dp_status_t  status_i,
  output rbfe_pkg::ctl_cmd_t    cmd_o
);

  rbfe_pkg::ctrl_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      rbfe_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = rbfe_pkg::ST_DISPATCH;
        end
      end
      rbfe_pkg::ST_DISPATCH: begin
        case (status_i.action)
          rbfe_pkg::ACT_TICK:    state_d = rbfe_pkg::ST_MUL;
          rbfe_pkg::ACT_SET_TGT: state_d = rbfe_pkg::ST_WRITE;
          rbfe_pkg::ACT_SET_CUR: state_d = rbfe_pkg::ST_WRITE;
          rbfe_pkg::ACT_ALL_TGT: state_d = rbfe_pkg::ST_SWEEP;
          rbfe_pkg::ACT_ALL_CUR: state_d = rbfe_pkg::ST_SWEEP;
          default:               state_d = rbfe_pkg::ST_FINISH;
        endcase
      end
      rbfe_pkg::ST_WRITE:  state_d = rbfe_pkg::ST_FINISH;
      rbfe_pkg::ST_SWEEP: begin
        if (status_i.last_idx) begin
          state_d = rbfe_pkg::ST_FINISH;
        end
      end
      rbfe_pkg::ST_MUL:    state_d = rbfe_pkg::ST_DIV_GO;
      rbfe_pkg::ST_DIV_GO: state_d = rbfe_pkg::ST_DIV;
      rbfe_pkg::ST_DIV: begin
        if (!status_i.div_busy) begin
          state_d = rbfe_pkg::ST_APPLY;
        end
      end
      rbfe_pkg::ST_APPLY: begin
        state_d = status_i.last_idx ? rbfe_pkg::ST_FINISH : rbfe_pkg::ST_MUL;
      end
      rbfe_pkg::ST_FINISH: begin
        if (status_i.out_free) begin
          state_d = rbfe_pkg::ST_IDLE;
        end
      end
      default: state_d = rbfe_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      rbfe_pkg::ST_IDLE: begin
        in_stall_o    = 1'b0;
        cmd_o.load_in = in_valid_i;
      end
      rbfe_pkg::ST_DISPATCH: begin
        cmd_o.clr_idx = 1'b1;
      end
      rbfe_pkg::ST_WRITE: begin
        cmd_o.use_bulb = 1'b1;
        cmd_o.wr_tgt   = status_i.action == rbfe_pkg::ACT_SET_TGT;
        cmd_o.wr_cur   = status_i.action == rbfe_pkg::ACT_SET_CUR;
      end
      rbfe_pkg::ST_SWEEP: begin
        cmd_o.wr_tgt  = status_i.action == rbfe_pkg::ACT_ALL_TGT;
        cmd_o.wr_cur  = status_i.action == rbfe_pkg::ACT_ALL_CUR;
        cmd_o.inc_idx = 1'b1;
      end
      rbfe_pkg::ST_MUL: begin
        cmd_o.mul_en = 1'b1;
      end
      rbfe_pkg::ST_DIV_GO: begin
        cmd_o.div_start = 1'b1;
      end
      rbfe_pkg::ST_DIV: ;
      rbfe_pkg::ST_APPLY: begin
        cmd_o.wr_fade = 1'b1;
        cmd_o.inc_idx = 1'b1;
      end
      rbfe_pkg::ST_FINISH: begin
        cmd_o.use_bulb = 1'b1;
        cmd_o.out_load = status_i.out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rbfe_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: design/rgb_bulb_fade_engine_core.sv
// ----------------------------------------------------------------------------
// rgb_bulb_fade_engine_core
// work: a read or unused action only loads the result, a single-bulb write
//   touches one bulb, set-all sweeps every bulb, a tick divides once per bulb
// throughput: one request at a time; the next is taken once the result is in
//   the output register, which may still be waiting on the consumer
// reset: async active low; colours return to their reset values at once
// ----------------------------------------------------------------------------
module rgb_bulb_fade_engine_core #(
  parameter int unsigned BULB_SLOTS = 10
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // request channel
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  rbfe_pkg::in_item_t                in_data_i,
  // result channel
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output rbfe_pkg::out_item_t               out_data_o,
  // register writes
  input  logic                              cfg_we_i,
  input  logic [rbfe_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [rbfe_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  // the controller steps through one request:
  //   dispatch on the stored action
  //   single write touches the addressed bulb once
  //   set-all sweeps every bulb, one per cycle
  //   tick walks bulbs: multiply step by 2*idx+4, divide by 3*num_bulbs,
  //   then update all three channels of that bulb together
  //   finish loads the result register once it is free
  rbfe_pkg::ctl_cmd_t   cmd;
  rbfe_pkg::dp_status_t status;

  rbfe_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // colour stores, per-bulb mismatch flags, divider and result register
  rbfe_dp #(
    .BULB_SLOTS (BULB_SLOTS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

  localparam logic [rbfe_pkg::BULB_W:0] SLOTS_EXT = (rbfe_pkg::BULB_W+1)'(BULB_SLOTS);

  // a taken request always makes the block busy in the next cycle
  a_busy_after_accept: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o
  ) else $error("request accepted back to back");

  // a new result only shows up at the end of work on a request
  a_result_after_work: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o)
  ) else $error("result appeared without a request in flight");

  // an unknown bulb reports black for both colours
  a_bad_bulb_zero: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && ({1'b0, out_data_o.bulb_index} >= SLOTS_EXT)) |->
      (out_data_o.cur_red == '0 && out_data_o.cur_green == '0 &&
       out_data_o.cur_blue == '0 && out_data_o.tgt_red == '0 &&
       out_data_o.tgt_green == '0 && out_data_o.tgt_blue == '0)
  ) else $error("out of range bulb reported nonzero colour");

endmodule

FILE: tb/tb_rgb_bulb_fade_engine_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rgb_bulb_fade_engine_core
// self-checking bench for the rgb bulb fade engine: a directed opening, then
// random requests under several register settings, each result checked
// field by field against a cycle-free model of the bulb colours
// ----------------------------------------------------------------------------
module tb_rgb_bulb_fade_engine_core;
  import rbfe_pkg::*;

  localparam int unsigned BULB_SLOTS     = 10;
  localparam int unsigned PHASE_ITEMS    = 155;
  localparam int unsigned OPEN_ITEMS     = 150;
  localparam int unsigned HOLD_CYCLES    = 400;
  // the slowest quiet stretch is a tick plus a long receiver hold-off of
  // HOLD_CYCLES, and this limit is several times that stretch
  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam int unsigned END_WAIT       = 200;
  localparam int unsigned MAX_PRINTS     = 40;

  // action codes the block does not decode; they must leave state alone
  localparam logic [ACTION_W-1:0] ACT_SPARE_LO = 3'd6;
  localparam logic [ACTION_W-1:0] ACT_SPARE_HI = 3'd7;

  // all block inputs start at known values
  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_stall_o;
  in_item_t              in_data_i   = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  out_item_t             out_data_o;
  logic                  cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;

  rgb_bulb_fade_engine_core #(
    .BULB_SLOTS(BULB_SLOTS)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // bench state
  // --------------------------------------------------------------------------
  in_item_t  pending_requests[$];   // requests not yet put on the bus
  out_item_t expected_reports[$];   // reports owed by the block, oldest first

  // shadow copy of the bulb colours and registers
  rgb_t             shadow_cur[BULB_SLOTS];
  rgb_t             shadow_tgt[BULB_SLOTS];
  logic [NB_W-1:0]  shadow_bulbs;
  logic [COLOR_W-1:0] shadow_snap;

  logic        calm     = 1'b0;     // no random idling while set
  logic        hold_req = 1'b0;     // toggled to ask the receiver for a hold-off
  logic        hold_seen;
  int unsigned hold_left;
  int unsigned quiet_cycles;

  int unsigned mismatches;
  int unsigned reports_checked;
  int unsigned n_ticks, n_writes, n_reads, n_spare, n_settings;
  bit          drv_take;
  out_item_t   want;

  task automatic flag_mismatch(string what, longint unsigned got, longint unsigned exp_val);
    if (mismatches < MAX_PRINTS)
      $display("%0t: %s mismatch, got %0d expected %0d", $time, what, got, exp_val);
    mismatches++;
  endtask

  // --------------------------------------------------------------------------
  // colour model
  // --------------------------------------------------------------------------
  // one channel one tick: exact rational move, floored, clamped to 0..255,
  // with a snap when already within the threshold
  function automatic logic [COLOR_W-1:0] fade_toward(logic [COLOR_W-1:0] cur,
                                                     logic [COLOR_W-1:0] tgt,
                                                     int unsigned idx,
                                                     logic [STEP_W-1:0] step);
    longint unsigned gap, den, base, m, v;
    gap = (cur > tgt) ? cur - tgt : tgt - cur;
    if (gap <= shadow_snap) return tgt;
    // q8.8 step times (2*idx+4) over 3*num_bulbs, all scaled by 256*3*nb
    den  = 768 * longint'(shadow_bulbs);
    base = longint'(cur) * den;
    m    = longint'(step) * (2 * idx + 4);
    if (tgt > cur) begin
      v = (base + m) / den;
      return (v > 255) ? 8'd255 : v[7:0];
    end
    if (m >= base) return '0;
    v = (base - m) / den;
    return v[7:0];
  endfunction

  // apply one request to the shadow state and build the report it owes
  function automatic out_item_t apply_request(in_item_t req);
    out_item_t res;
    rgb_t      col;
    bit        in_range;
    int        i;
    col      = {req.red, req.green, req.blue};
    in_range = req.bulb < BULB_SLOTS;
    case (req.action)
      ACT_TICK: begin
        for (i = 0; i < BULB_SLOTS; i++) begin
          shadow_cur[i].red   = fade_toward(shadow_cur[i].red, shadow_tgt[i].red, i,
                                            req.step_size);
          shadow_cur[i].green = fade_toward(shadow_cur[i].green, shadow_tgt[i].green, i,
                                            req.step_size);
          shadow_cur[i].blue  = fade_toward(shadow_cur[i].blue, shadow_tgt[i].blue, i,
                                            req.step_size);
        end
      end
      ACT_SET_TGT: if (in_range) shadow_tgt[req.bulb] = col;
      ACT_SET_CUR: if (in_range) shadow_cur[req.bulb] = col;
      ACT_ALL_TGT: for (i = 0; i < BULB_SLOTS; i++) shadow_tgt[i] = col;
      ACT_ALL_CUR: for (i = 0; i < BULB_SLOTS; i++) shadow_cur[i] = col;
      default: ;
    endcase
    res = '0;
    res.bulb_index = req.bulb;
    // out-of-range bulbs report all six colours as zero
    if (in_range) begin
      res.cur_red   = shadow_cur[req.bulb].red;
      res.cur_green = shadow_cur[req.bulb].green;
      res.cur_blue  = shadow_cur[req.bulb].blue;
      res.tgt_red   = shadow_tgt[req.bulb].red;
      res.tgt_green = shadow_tgt[req.bulb].green;
      res.tgt_blue  = shadow_tgt[req.bulb].blue;
    end
    for (i = 0; i < BULB_SLOTS; i++)
      if (shadow_cur[i] != shadow_tgt[i]) res.still_fading = 1'b1;
    return res;
  endfunction

  initial begin
    shadow_bulbs = NUM_BULBS_RESET;
    shadow_snap  = SNAP_THR_RESET;
    for (int i = 0; i < BULB_SLOTS; i++) begin
      shadow_cur[i] = CUR_RESET;
      shadow_tgt[i] = TGT_RESET;
    end
  end

  // --------------------------------------------------------------------------
  // request driver: presents the head of the pending queue, holds it while
  // stalled, predicts the report at the accepting edge
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i  <= '0;
    end else begin
      drv_take = in_valid_i && !in_stall_o;
      if (drv_take) begin
        expected_reports.push_back(apply_request(in_data_i));
        case (in_data_i.action)
          ACT_TICK:                                          n_ticks++;
          ACT_SET_TGT, ACT_SET_CUR, ACT_ALL_TGT, ACT_ALL_CUR: n_writes++;
          ACT_READ:                                          n_reads++;
          default:                                           n_spare++;
        endcase
      end
      // a stalled request stays put; otherwise maybe offer the next one
      if (in_valid_i && !drv_take) begin
        in_valid_i <= 1'b1;
      end else if (pending_requests.size() != 0 &&
                   (calm || $urandom_range(0, 99) >= 18)) begin
        in_valid_i <= 1'b1;
        in_data_i  <= pending_requests.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // receiver: random stalls plus one long hold-off counted here
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      hold_seen   <= 1'b0;
      hold_left   <= 0;
    end else if (hold_req != hold_seen) begin
      hold_seen   <= hold_req;
      hold_left   <= HOLD_CYCLES;
      out_stall_i <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= !calm && ($urandom_range(0, 99) < 18);
    end
  end

  // --------------------------------------------------------------------------
  // report checker
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      reports_checked++;
      if (expected_reports.size() == 0) begin
        flag_mismatch("unexpected report, bulb", out_data_o.bulb_index, 0);
      end else begin
        want = expected_reports.pop_front();
        if (out_data_o.bulb_index !== want.bulb_index)
          flag_mismatch("bulb_index", out_data_o.bulb_index, want.bulb_index);
        if (out_data_o.cur_red !== want.cur_red)
          flag_mismatch("cur_red", out_data_o.cur_red, want.cur_red);
        if (out_data_o.cur_green !== want.cur_green)
          flag_mismatch("cur_green", out_data_o.cur_green, want.cur_green);
        if (out_data_o.cur_blue !== want.cur_blue)
          flag_mismatch("cur_blue", out_data_o.cur_blue, want.cur_blue);
        if (out_data_o.tgt_red !== want.tgt_red)
          flag_mismatch("tgt_red", out_data_o.tgt_red, want.tgt_red);
        if (out_data_o.tgt_green !== want.tgt_green)
          flag_mismatch("tgt_green", out_data_o.tgt_green, want.tgt_green);
        if (out_data_o.tgt_blue !== want.tgt_blue)
          flag_mismatch("tgt_blue", out_data_o.tgt_blue, want.tgt_blue);
        if (out_data_o.still_fading !== want.still_fading)
          flag_mismatch("still_fading", out_data_o.still_fading, want.still_fading);
      end
    end
  end

  // watchdog: too long without any handshake on either channel
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", quiet_cycles);
      $display("tb_rgb_bulb_fade_engine_core failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------
  task automatic queue_request(logic [ACTION_W-1:0] act, logic [BULB_W-1:0] bulb,
                               logic [COLOR_W-1:0] r, logic [COLOR_W-1:0] g,
                               logic [COLOR_W-1:0] b, logic [STEP_W-1:0] step);
    in_item_t req;
    req.action    = act;
    req.bulb      = bulb;
    req.red       = r;
    req.green     = g;
    req.blue      = b;
    req.step_size = step;
    pending_requests.push_back(req);
  endtask

  // ticks and reads dominate so colours fade across many requests; small
  // steps keep bulbs mid-fade, large ones hit the clamps
  task automatic queue_random_request();
    int unsigned         pick;
    logic [ACTION_W-1:0] act;
    logic [BULB_W-1:0]   bulb;
    logic [STEP_W-1:0]   step;
    pick = $urandom_range(0, 99);
    if      (pick < 35) act = ACT_TICK;
    else if (pick < 50) act = ACT_SET_TGT;
    else if (pick < 60) act = ACT_SET_CUR;
    else if (pick < 64) act = ACT_ALL_TGT;
    else if (pick < 68) act = ACT_ALL_CUR;
    else if (pick < 95) act = ACT_READ;
    else                act = $urandom_range(0, 1) ? ACT_SPARE_HI : ACT_SPARE_LO;
    if ($urandom_range(0, 99) < 85) bulb = $urandom_range(0, BULB_SLOTS - 1);
    else                            bulb = $urandom_range(BULB_SLOTS, 15);
    pick = $urandom_range(0, 9);
    if      (pick < 4) step = $urandom_range(0, 300);
    else if (pick < 7) step = $urandom_range(301, 4000);
    else if (pick < 9) step = $urandom();
    else               step = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
    queue_request(act, bulb, $urandom(), $urandom(), $urandom(), step);
  endtask

  // register write, mirrored into the shadow copy
  task automatic write_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    if (idx == CFG_NUM_BULBS) begin
      // the block saturates the bulb count into its legal range
      if (val < NUM_BULBS_MIN)      shadow_bulbs = NUM_BULBS_MIN;
      else if (val > NUM_BULBS_MAX) shadow_bulbs = NUM_BULBS_MAX;
      else                          shadow_bulbs = val[NB_W-1:0];
    end else begin
      shadow_snap = val;
    end
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // sender pause: nothing queued, nothing on the bus, every report back
  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_requests.size() != 0 || in_valid_i || expected_reports.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // test sequence
  // --------------------------------------------------------------------------
  initial begin
    static logic [CFG_DATA_W-1:0] bulb_setting[6] = '{8'd0, 8'd7, 8'd3, 8'd255, 8'd2, 8'd5};
    static logic [CFG_DATA_W-1:0] snap_setting[6] = '{8'd0, 8'd255, 8'd5, 8'd1, 8'd40, 8'd128};

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);

    // directed opening under reset register values
    queue_request(ACT_READ, 4'd0, 8'd0, 8'd0, 8'd0, 16'd0);          // reset colours
    queue_request(ACT_READ, 4'd9, 8'd0, 8'd0, 8'd0, 16'd0);
    queue_request(ACT_READ, 4'd15, 8'd0, 8'd0, 8'd0, 16'd0);         // out of range
    queue_request(ACT_SPARE_LO, 4'd3, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF);
    queue_request(ACT_SPARE_HI, 4'd10, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF);
    queue_request(ACT_TICK, 4'd1, 8'd0, 8'd0, 8'd0, 16'd0);          // zero step
    queue_request(ACT_TICK, 4'd2, 8'd0, 8'd0, 8'd0, 16'hFFFF);       // biggest step
    queue_request(ACT_READ, 4'd5, 8'd0, 8'd0, 8'd0, 16'd0);
    queue_request(ACT_SET_TGT, 4'd9, 8'd255, 8'd255, 8'd255, 16'd0);
    queue_request(ACT_SET_CUR, 4'd0, 8'd255, 8'd255, 8'd255, 16'd0);
    queue_request(ACT_SET_TGT, 4'd10, 8'hAA, 8'h55, 8'hAA, 16'd0);   // ignored write
    queue_request(ACT_SET_CUR, 4'd15, 8'h55, 8'hAA, 8'h55, 16'd0);   // ignored write
    queue_request(ACT_TICK, 4'd0, 8'd0, 8'd0, 8'd0, 16'hFFFF);       // clamp low and high
    queue_request(ACT_ALL_TGT, 4'd7, 8'd0, 8'd0, 8'd0, 16'd0);
    queue_request(ACT_ALL_CUR, 4'd8, 8'd255, 8'd255, 8'd255, 16'd0);
    queue_request(ACT_TICK, 4'd4, 8'd0, 8'd0, 8'd0, 16'd256);        // step of one code in q8.8
    queue_request(ACT_READ, 4'd4, 8'd0, 8'd0, 8'd0, 16'd0);
    queue_request(ACT_SET_CUR, 4'd2, 8'd10, 8'd5, 8'd12, 16'd0);     // within snap reach
    queue_request(ACT_TICK, 4'd2, 8'd0, 8'd0, 8'd0, 16'd0);          // snaps on zero step
    queue_request(ACT_ALL_TGT, 4'd0, 8'd255, 8'd0, 8'd128, 16'd0);
    queue_request(ACT_ALL_CUR, 4'd0, 8'd0, 8'd255, 8'd127, 16'd0);
    queue_request(ACT_TICK, 4'd6, 8'd0, 8'd0, 8'd0, 16'd1);          // smallest nonzero
    queue_request(ACT_SET_TGT, 4'd0, 8'd1, 8'd254, 8'd128, 16'hFFFF);
    queue_request(ACT_READ, 4'd1, 8'd0, 8'd0, 8'd0, 16'hFFFF);
    repeat (OPEN_ITEMS) queue_random_request();
    wait_drained();
    n_settings = 1;

    // register sweeps, each entered only with the block idle
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(CFG_NUM_BULBS, bulb_setting[ph]);
      write_reg(CFG_SNAP_THR, snap_setting[ph]);
      // one phase runs with no idling on either side and a long hold-off
      if (ph == 2) calm <= 1'b1;
      @(negedge clk_i);
      repeat (PHASE_ITEMS) queue_random_request();
      if (ph == 2) begin
        repeat (60) @(posedge clk_i);
        hold_req <= ~hold_req;
      end
      wait_drained();
      calm <= 1'b0;
      n_settings++;
    end

    repeat (END_WAIT) @(posedge clk_i);
    if (expected_reports.size() != 0)
      flag_mismatch("reports still owed", expected_reports.size(), 0);

    $display("covered %0d ticks, %0d colour writes, %0d reads, %0d unused actions",
             n_ticks, n_writes, n_reads, n_spare);
    $display("%0d reports checked over %0d register settings, %0d mismatches",
             reports_checked, n_settings, mismatches);
    if (mismatches == 0) begin
      $display("tb_rgb_bulb_fade_engine_core passed");
    end else begin
      $display("tb_rgb_bulb_fade_engine_core failed");
    end
    $finish;
  end

endmodule
